### hdl/lcbm_pkg.sv
// shared types and constants for the lamp color and brightness mapper
package lcbm_pkg;

    // field widths
    localparam int COLOR_W  = 8;
    localparam int TEMP_W   = 16;
    localparam int BRIGHT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // q10 interpolation position, 0..1024 needs eleven bits
    localparam int Q10_SHIFT = 10;
    localparam int ALPHA_W   = Q10_SHIFT + 1;
    localparam int Q10_ONE   = 1 << Q10_SHIFT;

    // warm and cool white points, cool is full on every channel
    localparam int WARM_G     = 147;
    localparam int WARM_B     = 41;
    localparam int COOL_LEVEL = 255;
    localparam int GREEN_STEP = COOL_LEVEL - WARM_G;
    localparam int BLUE_STEP  = COOL_LEVEL - WARM_B;

    // brightness curve
    localparam int BRIGHT_MAX = 100;
    localparam int KNEE_PCT   = 10;
    localparam int QUAD_DIV   = 7921;

    // reciprocal multipliers for constant divides
    localparam int TENTH_MUL    = 205;   // x / 10 for x below 256
    localparam int TENTH_SHIFT  = 11;
    localparam int NINTH_MUL    = 57;    // x / 9 for x up to 225
    localparam int NINTH_SHIFT  = 9;
    localparam int QUAD_SHIFT   = 24;    // x / 7921, low by at most one
    localparam int QUAD_MUL     = (1 << QUAD_SHIFT) / QUAD_DIV;
    localparam int DIV255_MUL   = 32897; // x / 255 exact for 16 bit x
    localparam int DIV255_SHIFT = 23;

    // register reset values
    localparam int MIN_PWM_RST  = 0;
    localparam int MAX_PWM_RST  = 255;
    localparam int CCT_LOW_RST  = 2700;
    localparam int CCT_HIGH_RST = 6500;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PWM  = 2'd0,
        CFG_MAX_PWM  = 2'd1,
        CFG_CCT_LOW  = 2'd2,
        CFG_CCT_HIGH = 2'd3
    } cfg_reg_t;

    // per item fields that ride along the divider
    typedef struct packed {
        logic                kind;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [BRIGHT_W-1:0] bright;
    } side_t;

endpackage

### hdl/lcbm_div.sv
// pipelined restoring divider for the q10 interpolation position
module lcbm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [lcbm_pkg::TEMP_W-1:0]    num,
    input  logic [lcbm_pkg::TEMP_W-1:0]    den,
    input  lcbm_pkg::side_t                in_side,
    output logic                           out_valid,
    output logic [lcbm_pkg::ALPHA_W-1:0]   out_quot,
    output lcbm_pkg::side_t                out_side
);

    localparam int NS = lcbm_pkg::ALPHA_W;
    localparam int W  = lcbm_pkg::TEMP_W;

    // one quotient bit per stage, msb first
    logic                vld_reg  [NS];
    logic [W-1:0]        rem_reg  [NS];
    logic [W-1:0]        den_reg  [NS];
    logic [NS-1:0]       quot_reg [NS];
    lcbm_pkg::side_t     side_reg [NS];

    // stage inputs: stage 0 from the ports, others from the previous stage
    logic [W:0]          cand_in  [NS];
    logic [W-1:0]        den_in   [NS];
    logic [NS-1:0]       quot_in  [NS];
    logic                vld_in   [NS];
    lcbm_pkg::side_t     side_in  [NS];

    // first stage compares num itself since num never exceeds den
    assign cand_in[0] = {1'b0, num};
    assign den_in[0]  = den;
    assign quot_in[0] = '0;
    assign vld_in[0]  = in_valid;
    assign side_in[0] = in_side;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic         bit_q;
            logic [W:0]   diff;
            logic [W-1:0] rem_next;
            logic [NS-1:0] quot_next;

            if (k > 0) begin : g_link
                assign cand_in[k] = {rem_reg[k-1], 1'b0};
                assign den_in[k]  = den_reg[k-1];
                assign quot_in[k] = quot_reg[k-1];
                assign vld_in[k]  = vld_reg[k-1];
                assign side_in[k] = side_reg[k-1];
            end

            // compare and subtract
            always_comb begin
                diff  = cand_in[k] - {1'b0, den_in[k]};
                bit_q = (cand_in[k] >= {1'b0, den_in[k]});
                rem_next = bit_q ? diff[W-1:0] : cand_in[k][W-1:0];
                quot_next = quot_in[k];
                quot_next[NS-1-k] = bit_q;
            end

            // stage valid
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_in[k];
                end
            end

            // stage payload
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_in[k];
                    quot_reg[k] <= quot_next;
                    side_reg[k] <= side_in[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign out_quot  = quot_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

### hdl/lamp_color_brightness_mapper.sv
// top level of the lamp color and brightness mapper
//
// Usage: each transaction on the s_ channel carries a mode, an rgb color, a color
// temperature and a brightness percent; the m_ channel returns one transaction with
// three 8-bit pwm duty values for it, in order.
// The cfg channel writes min_pwm, max_pwm, cct_low and cct_high by index; it is
// always ready, and the user must write it only while no transaction is in flight;
// the block itself does not enforce this. One transaction can be accepted every
// cycle while the output is not stalled; the pipeline depth comes from the input
// register, the 11-stage divider that forms the q10 temperature position, and six
// stages for the lerp, the brightness curve and the final scale by 255.
// Reset clears every pipeline valid bit and loads the register defaults
// (0, 255, 2700, 6500).
// While a result waits on m_valid with m_ready low, the whole pipeline holds and
// s_ready is low; nothing is dropped or repeated.
module lamp_color_brightness_mapper (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [lcbm_pkg::COLOR_W-1:0]      s_red_in,
    input  logic [lcbm_pkg::COLOR_W-1:0]      s_green_in,
    input  logic [lcbm_pkg::COLOR_W-1:0]      s_blue_in,
    input  logic [lcbm_pkg::TEMP_W-1:0]       s_color_temp,
    input  logic [lcbm_pkg::BRIGHT_W-1:0]     s_brightness,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lcbm_pkg::COLOR_W-1:0]      m_red_out,
    output logic [lcbm_pkg::COLOR_W-1:0]      m_green_out,
    output logic [lcbm_pkg::COLOR_W-1:0]      m_blue_out
);

    localparam int CW = lcbm_pkg::COLOR_W;
    localparam int TW = lcbm_pkg::TEMP_W;
    localparam int BW = lcbm_pkg::BRIGHT_W;
    localparam int AW = lcbm_pkg::ALPHA_W;

    // configuration registers
    logic [CW-1:0] min_pwm_reg;
    logic [CW-1:0] max_pwm_reg;
    logic [TW-1:0] cct_low_reg;
    logic [TW-1:0] cct_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pwm_reg  <= CW'(lcbm_pkg::MIN_PWM_RST);
            max_pwm_reg  <= CW'(lcbm_pkg::MAX_PWM_RST);
            cct_low_reg  <= TW'(lcbm_pkg::CCT_LOW_RST);
            cct_high_reg <= TW'(lcbm_pkg::CCT_HIGH_RST);
        end else if (cfg_valid) begin
            unique case (lcbm_pkg::cfg_reg_t'(cfg_index))
                lcbm_pkg::CFG_MIN_PWM:  min_pwm_reg  <= cfg_data[CW-1:0];
                lcbm_pkg::CFG_MAX_PWM:  max_pwm_reg  <= cfg_data[CW-1:0];
                lcbm_pkg::CFG_CCT_LOW:  cct_low_reg  <= cfg_data[TW-1:0];
                lcbm_pkg::CFG_CCT_HIGH: cct_high_reg <= cfg_data[TW-1:0];
            endcase
        end
    end

    // derived curve constants: pwm range, knee offset, quadratic span
    logic [CW-1:0] range_next;
    logic [15:0]   tenth_prod;
    logic [CW-1:0] range_reg;
    logic [4:0]    koff_reg;
    logic [CW-1:0] qspan_reg;

    always_comb begin
        range_next = (max_pwm_reg >= min_pwm_reg) ? (max_pwm_reg - min_pwm_reg) : '0;
        tenth_prod = 16'(range_next) * 16'(lcbm_pkg::TENTH_MUL);
    end

    always_ff @(posedge aclk) begin
        range_reg <= range_next;
        koff_reg  <= 5'(tenth_prod >> lcbm_pkg::TENTH_SHIFT);
        qspan_reg <= range_reg - CW'(koff_reg);
    end

    // whole pipeline advances when the output register is free or being taken
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage a: input register
    logic            a_vld_reg;
    lcbm_pkg::side_t a_side_reg;
    logic [TW-1:0]   a_temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg.kind   <= s_kind;
            a_side_reg.red    <= s_red_in;
            a_side_reg.green  <= s_green_in;
            a_side_reg.blue   <= s_blue_in;
            a_side_reg.bright <= s_brightness;
            a_temp_reg        <= s_color_temp;
        end
    end

    // clamp temperature, form divider operands, saturate brightness
    logic [TW-1:0]   t_lo;
    logic [TW-1:0]   t_cl;
    logic            span_pos;
    logic [TW-1:0]   div_num;
    logic [TW-1:0]   div_den;
    lcbm_pkg::side_t div_side;

    always_comb begin
        t_lo     = (a_temp_reg < cct_low_reg) ? cct_low_reg : a_temp_reg;
        t_cl     = (t_lo > cct_high_reg) ? cct_high_reg : t_lo;
        span_pos = (cct_high_reg > cct_low_reg);
        div_num  = span_pos ? (t_cl - cct_low_reg) : '0;
        div_den  = span_pos ? (cct_high_reg - cct_low_reg) : TW'(1);
        div_side = a_side_reg;
        if (a_side_reg.bright > BW'(lcbm_pkg::BRIGHT_MAX)) begin
            div_side.bright = BW'(lcbm_pkg::BRIGHT_MAX);
        end
    end

    // divider stages
    logic            d_vld;
    logic [AW-1:0]   d_alpha;
    lcbm_pkg::side_t d_side;

    lcbm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_vld_reg),
        .num       (div_num),
        .den       (div_den),
        .in_side   (div_side),
        .out_valid (d_vld),
        .out_quot  (d_alpha),
        .out_side  (d_side)
    );

    // stage p1: lerp toward cool white, split brightness into linear or square
    logic [17:0]   g_step;
    logic [17:0]   b_step;
    logic [CW-1:0] cct_green;
    logic [CW-1:0] cct_blue;
    logic [3:0]    bm1;
    logic [BW-1:0] n_quad;

    logic          p1_vld_reg;
    logic [CW-1:0] p1_red_reg;
    logic [CW-1:0] p1_green_reg;
    logic [CW-1:0] p1_blue_reg;
    logic          p1_bz_reg;
    logic          p1_lin_reg;
    logic [7:0]    p1_lin_num_reg;
    logic [12:0]   p1_nsq_reg;

    always_comb begin
        g_step    = 18'(d_alpha) * 18'(lcbm_pkg::GREEN_STEP);
        b_step    = 18'(d_alpha) * 18'(lcbm_pkg::BLUE_STEP);
        cct_green = CW'(lcbm_pkg::WARM_G) + CW'(g_step >> lcbm_pkg::Q10_SHIFT);
        cct_blue  = CW'(lcbm_pkg::WARM_B) + CW'(b_step >> lcbm_pkg::Q10_SHIFT);
        bm1       = 4'(d_side.bright - BW'(1));
        n_quad    = d_side.bright - BW'(lcbm_pkg::KNEE_PCT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_red_reg     <= d_side.kind ? CW'(lcbm_pkg::COOL_LEVEL) : d_side.red;
            p1_green_reg   <= d_side.kind ? cct_green : d_side.green;
            p1_blue_reg    <= d_side.kind ? cct_blue : d_side.blue;
            p1_bz_reg      <= (d_side.bright == '0);
            p1_lin_reg     <= (d_side.bright <= BW'(lcbm_pkg::KNEE_PCT));
            p1_lin_num_reg <= 8'(9'(bm1) * 9'(koff_reg));
            p1_nsq_reg     <= 13'(14'(n_quad) * 14'(n_quad));
        end
    end

    // stage p2: linear segment divide by nine, quadratic numerator
    logic [13:0]   ninth_prod;
    logic [CW-1:0] lin_t;

    logic          p2_vld_reg;
    logic [CW-1:0] p2_red_reg;
    logic [CW-1:0] p2_green_reg;
    logic [CW-1:0] p2_blue_reg;
    logic          p2_bz_reg;
    logic          p2_lin_reg;
    logic [CW-1:0] p2_lin_t_reg;
    logic [20:0]   p2_qx_reg;

    always_comb begin
        ninth_prod = 14'(p1_lin_num_reg) * 14'(lcbm_pkg::NINTH_MUL);
        lin_t      = CW'(ninth_prod >> lcbm_pkg::NINTH_SHIFT) + min_pwm_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_red_reg   <= p1_red_reg;
            p2_green_reg <= p1_green_reg;
            p2_blue_reg  <= p1_blue_reg;
            p2_bz_reg    <= p1_bz_reg;
            p2_lin_reg   <= p1_lin_reg;
            p2_lin_t_reg <= lin_t;
            p2_qx_reg    <= 21'(p1_nsq_reg) * 21'(qspan_reg);
        end
    end

    // stage p3: estimate quotient by 7921 with a reciprocal
    logic [32:0]   quad_est;

    logic          p3_vld_reg;
    logic [CW-1:0] p3_red_reg;
    logic [CW-1:0] p3_green_reg;
    logic [CW-1:0] p3_blue_reg;
    logic          p3_bz_reg;
    logic          p3_lin_reg;
    logic [CW-1:0] p3_lin_t_reg;
    logic [20:0]   p3_qx_reg;
    logic [8:0]    p3_q0_reg;

    assign quad_est = 33'(p2_qx_reg) * 33'(lcbm_pkg::QUAD_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (en) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_red_reg   <= p2_red_reg;
            p3_green_reg <= p2_green_reg;
            p3_blue_reg  <= p2_blue_reg;
            p3_bz_reg    <= p2_bz_reg;
            p3_lin_reg   <= p2_lin_reg;
            p3_lin_t_reg <= p2_lin_t_reg;
            p3_qx_reg    <= p2_qx_reg;
            p3_q0_reg    <= 9'(quad_est >> lcbm_pkg::QUAD_SHIFT);
        end
    end

    // stage p4: correct the quotient, cap at the top, pick the target
    logic [21:0]   quad_back;
    logic [21:0]   quad_rem;
    logic [8:0]    quad_q;
    logic [9:0]    knee;
    logic [9:0]    top;
    logic [9:0]    quad_t;
    logic [9:0]    quad_cap;
    logic [CW-1:0] target;

    logic          p4_vld_reg;
    logic [CW-1:0] p4_red_reg;
    logic [CW-1:0] p4_green_reg;
    logic [CW-1:0] p4_blue_reg;
    logic [CW-1:0] p4_target_reg;

    always_comb begin
        quad_back = 22'(p3_q0_reg) * 22'(lcbm_pkg::QUAD_DIV);
        quad_rem  = 22'(p3_qx_reg) - quad_back;
        quad_q    = p3_q0_reg + 9'(quad_rem >= 22'(lcbm_pkg::QUAD_DIV));
        knee      = 10'(min_pwm_reg) + 10'(koff_reg);
        top       = 10'(min_pwm_reg) + 10'(range_reg);
        quad_t    = knee + 10'(quad_q);
        quad_cap  = (quad_t > top) ? top : quad_t;
        if (p3_bz_reg) begin
            target = '0;
        end else if (p3_lin_reg) begin
            target = p3_lin_t_reg;
        end else begin
            target = CW'(quad_cap);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_vld_reg <= 1'b0;
        end else if (en) begin
            p4_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_red_reg    <= p3_red_reg;
            p4_green_reg  <= p3_green_reg;
            p4_blue_reg   <= p3_blue_reg;
            p4_target_reg <= target;
        end
    end

    // stage p5: channel times target
    logic        p5_vld_reg;
    logic [15:0] p5_red_reg;
    logic [15:0] p5_green_reg;
    logic [15:0] p5_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_vld_reg <= 1'b0;
        end else if (en) begin
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_red_reg   <= 16'(p4_red_reg) * 16'(p4_target_reg);
            p5_green_reg <= 16'(p4_green_reg) * 16'(p4_target_reg);
            p5_blue_reg  <= 16'(p4_blue_reg) * 16'(p4_target_reg);
        end
    end

    // output register: divide by 255 through an exact reciprocal
    logic [31:0]   red_div;
    logic [31:0]   green_div;
    logic [31:0]   blue_div;
    logic [CW-1:0] m_red_out_reg;
    logic [CW-1:0] m_green_out_reg;
    logic [CW-1:0] m_blue_out_reg;

    always_comb begin
        red_div   = 32'(p5_red_reg) * 32'(lcbm_pkg::DIV255_MUL);
        green_div = 32'(p5_green_reg) * 32'(lcbm_pkg::DIV255_MUL);
        blue_div  = 32'(p5_blue_reg) * 32'(lcbm_pkg::DIV255_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_red_out_reg   <= CW'(red_div >> lcbm_pkg::DIV255_SHIFT);
            m_green_out_reg <= CW'(green_div >> lcbm_pkg::DIV255_SHIFT);
            m_blue_out_reg  <= CW'(blue_div >> lcbm_pkg::DIV255_SHIFT);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_red_out_reg;
    assign m_green_out = m_green_out_reg;
    assign m_blue_out  = m_blue_out_reg;

    // interpolation position never passes one in q10
    assert property (@(posedge aclk) disable iff (!aresetn)
        d_vld |-> (d_alpha <= AW'(lcbm_pkg::Q10_ONE)))
        else $error("divider position above one");

    // lerp result stays between warm and cool white
    assert property (@(posedge aclk) disable iff (!aresetn)
        (d_vld && d_side.kind) |->
            (cct_green >= CW'(lcbm_pkg::WARM_G) && cct_blue >= CW'(lcbm_pkg::WARM_B)))
        else $error("color temperature lerp out of range");

    // reciprocal estimate is at most one low
    assert property (@(posedge aclk) disable iff (!aresetn)
        p3_vld_reg |-> (quad_rem < 22'(2 * lcbm_pkg::QUAD_DIV)))
        else $error("quadratic quotient estimate off by more than one");

    // a stall freezes the last stage and the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(p5_vld_reg) && $stable(p5_red_reg) && $stable(m_red_out_reg)
                 && $stable(m_green_out_reg) && $stable(m_blue_out_reg)))
        else $error("pipeline moved during a stall");

endmodule

### bench/lamp_color_brightness_mapper_tb.sv
// self-checking testbench for the lamp color and brightness mapper
module lamp_color_brightness_mapper_tb;

    // run bounds
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned SETTING_ITEMS = 120;

    // color and curve constants for the duty predictor
    localparam int unsigned WARM_RED   = 255;
    localparam int unsigned WARM_GREEN = 147;
    localparam int unsigned WARM_BLUE  = 41;
    localparam int unsigned COOL_ALL   = 255;
    localparam int unsigned Q10_UNIT   = 1024;
    localparam int unsigned CURVE_DIV  = 7921;
    localparam int unsigned KNEE_LEVEL = 10;
    localparam int unsigned FULL_PCT   = 100;

    typedef struct packed {
        logic [lcbm_pkg::COLOR_W-1:0] red;
        logic [lcbm_pkg::COLOR_W-1:0] green;
        logic [lcbm_pkg::COLOR_W-1:0] blue;
    } duty_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration channel
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lcbm_pkg::CFG_IDX_W-1:0]  cfg_index = lcbm_pkg::CFG_MIN_PWM;
    logic [lcbm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // request channel
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic                          s_kind       = 1'b0;
    logic [lcbm_pkg::COLOR_W-1:0]  s_red_in     = '0;
    logic [lcbm_pkg::COLOR_W-1:0]  s_green_in   = '0;
    logic [lcbm_pkg::COLOR_W-1:0]  s_blue_in    = '0;
    logic [lcbm_pkg::TEMP_W-1:0]   s_color_temp = '0;
    logic [lcbm_pkg::BRIGHT_W-1:0] s_brightness = '0;

    // result channel
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [lcbm_pkg::COLOR_W-1:0] m_red_out;
    logic [lcbm_pkg::COLOR_W-1:0] m_green_out;
    logic [lcbm_pkg::COLOR_W-1:0] m_blue_out;

    // register shadow copies
    int unsigned pwm_floor  = 0;
    int unsigned pwm_ceil   = 255;
    int unsigned cct_warm_k = 2700;
    int unsigned cct_cool_k = 6500;

    duty_t       pending_duty[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned stall_left     = 0;
    bit          idle_on        = 1'b1;

    lamp_color_brightness_mapper i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_color_temp (s_color_temp),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** lamp_color_brightness_mapper: FAILED **");
            $finish;
        end
    end

    // idle length: mostly short, a few long
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // brightness curve target level for the current pwm limits
    function automatic int unsigned curve_level(int unsigned bright);
        int unsigned span;
        int unsigned knee;
        int unsigned top;
        int unsigned n;
        int unsigned lvl;
        span = (pwm_ceil >= pwm_floor) ? pwm_ceil - pwm_floor : 0;
        knee = pwm_floor + span / 10;
        if (bright > FULL_PCT)
            bright = FULL_PCT;
        if (bright == 0)
            return 0;
        if (bright <= KNEE_LEVEL)
            return (bright - 1) * (knee - pwm_floor) / 9 + pwm_floor;
        top = (pwm_ceil >= knee) ? pwm_ceil : knee;
        n   = bright - KNEE_LEVEL;
        lvl = knee + n * n * (top - knee) / CURVE_DIV;
        if (lvl > top)
            lvl = top;
        return lvl;
    endfunction

    function automatic int unsigned blend_q10(int unsigned warm, int unsigned pos);
        return (warm * (Q10_UNIT - pos) + COOL_ALL * pos) / Q10_UNIT;
    endfunction

    function automatic logic [lcbm_pkg::COLOR_W-1:0] scale_duty(int unsigned chan,
                                                                int unsigned lvl);
        if (chan == 0 || lvl == 0)
            return '0;
        return 8'((chan * lvl / 255) & 32'hff);
    endfunction

    // expected pwm duties for one request
    function automatic duty_t predict_duty(logic kind, logic [lcbm_pkg::COLOR_W-1:0] r,
                                           logic [lcbm_pkg::COLOR_W-1:0] g,
                                           logic [lcbm_pkg::COLOR_W-1:0] b,
                                           logic [lcbm_pkg::TEMP_W-1:0] temp,
                                           logic [lcbm_pkg::BRIGHT_W-1:0] bright);
        int unsigned rc;
        int unsigned gc;
        int unsigned bc;
        int unsigned tk;
        int unsigned span;
        int unsigned pos;
        int unsigned lvl;
        duty_t       duty;
        rc = 32'(r);
        gc = 32'(g);
        bc = 32'(b);
        if (kind) begin
            // clamp low bound first, then high bound
            tk = 32'(temp);
            if (tk < cct_warm_k)
                tk = cct_warm_k;
            if (tk > cct_cool_k)
                tk = cct_cool_k;
            span = (cct_cool_k > cct_warm_k) ? cct_cool_k - cct_warm_k : 0;
            pos  = (span == 0) ? 0 : (tk - cct_warm_k) * Q10_UNIT / span;
            if (pos > Q10_UNIT)
                pos = Q10_UNIT;
            rc = blend_q10(WARM_RED, pos);
            gc = blend_q10(WARM_GREEN, pos);
            bc = blend_q10(WARM_BLUE, pos);
        end
        lvl = curve_level(32'(bright));
        duty.red   = scale_duty(rc, lvl);
        duty.green = scale_duty(gc, lvl);
        duty.blue  = scale_duty(bc, lvl);
        return duty;
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        duty_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_duty.size() == 0) begin
                $display("%0t: unexpected result, got %0d %0d %0d", $time,
                         m_red_out, m_green_out, m_blue_out);
                mismatch_count++;
            end else begin
                want = pending_duty.pop_front();
                if (m_red_out !== want.red) begin
                    $display("%0t: red_out expected %0d, got %0d", $time, want.red, m_red_out);
                    mismatch_count++;
                end
                if (m_green_out !== want.green) begin
                    $display("%0t: green_out expected %0d, got %0d", $time, want.green,
                             m_green_out);
                    mismatch_count++;
                end
                if (m_blue_out !== want.blue) begin
                    $display("%0t: blue_out expected %0d, got %0d", $time, want.blue,
                             m_blue_out);
                    mismatch_count++;
                end
            end
        end
    end

    // send one request transaction and record its expected duties
    task automatic send_request(input logic kind, input logic [lcbm_pkg::COLOR_W-1:0] r,
                                input logic [lcbm_pkg::COLOR_W-1:0] g,
                                input logic [lcbm_pkg::COLOR_W-1:0] b,
                                input logic [lcbm_pkg::TEMP_W-1:0] temp,
                                input logic [lcbm_pkg::BRIGHT_W-1:0] bright);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_red_in     <= r;
        s_green_in   <= g;
        s_blue_in    <= b;
        s_color_temp <= temp;
        s_brightness <= bright;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_duty.push_back(predict_duty(kind, r, g, b, temp, bright));
    endtask

    // let every pending result come out and the pipeline go empty
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_duty.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input lcbm_pkg::cfg_reg_t idx,
                             input logic [lcbm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            lcbm_pkg::CFG_MIN_PWM:  pwm_floor  = 32'(data[7:0]);
            lcbm_pkg::CFG_MAX_PWM:  pwm_ceil   = 32'(data[7:0]);
            lcbm_pkg::CFG_CCT_LOW:  cct_warm_k = 32'(data);
            lcbm_pkg::CFG_CCT_HIGH: cct_cool_k = 32'(data);
            default: ;
        endcase
    endtask

    // write all four limits while the block is idle
    task automatic program_limits(input int unsigned lo_pwm, input int unsigned hi_pwm,
                                  input int unsigned lo_k, input int unsigned hi_k);
        quiesce();
        // upper byte of the 8-bit registers is junk that must be ignored
        write_reg(lcbm_pkg::CFG_MIN_PWM, {8'($urandom), 8'(lo_pwm)});
        write_reg(lcbm_pkg::CFG_MAX_PWM, {8'($urandom), 8'(hi_pwm)});
        write_reg(lcbm_pkg::CFG_CCT_LOW, 16'(lo_k));
        write_reg(lcbm_pkg::CFG_CCT_HIGH, 16'(hi_k));
        cfg_valid <= 1'b0;
    endtask

    // brightness curve edges, mostly with full white, at reset limits
    task automatic test_rgb_curve();
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd0);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd1);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd5);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd10);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd11);
        send_request(1'b0, 8'd200, 8'd100, 8'd7, 16'd0, 7'd50);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd99);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd100);
        // above hundred saturates
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'hffff, 7'd101);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'hffff, 7'd127);
        // zero channels give zero duty
        send_request(1'b0, 8'd0, 8'd128, 8'd1, 16'd0, 7'd100);
    endtask

    // temperature clamp and interpolation at reset limits
    task automatic test_cct_clamp();
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'd0, 7'd100);
        send_request(1'b1, 8'd255, 8'd255, 8'd255, 16'd2699, 7'd100);
        send_request(1'b1, 8'd13, 8'd0, 8'd99, 16'd2700, 7'd100);
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'd4600, 7'd60);
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'd6500, 7'd100);
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'd6501, 7'd3);
        send_request(1'b1, 8'd255, 8'd0, 8'd255, 16'hffff, 7'd127);
    endtask

    // inverted and equal limits for pwm and temperature
    task automatic test_inverted_limits();
        program_limits(200, 50, 6500, 2700);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd1);
        send_request(1'b0, 8'd255, 8'd128, 8'd1, 16'd0, 7'd100);
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'd0, 7'd100);
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'hffff, 7'd40);
        program_limits(77, 77, 5000, 5000);
        send_request(1'b1, 8'd0, 8'd0, 8'd0, 16'd5000, 7'd100);
        send_request(1'b0, 8'd255, 8'd255, 8'd255, 16'd0, 7'd9);
    endtask

    function automatic logic [lcbm_pkg::COLOR_W-1:0] rand_color();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    // temperatures spread around and onto the programmed bounds, some fully random
    function automatic logic [lcbm_pkg::TEMP_W-1:0] rand_temp();
        int unsigned pick;
        int          lo;
        int          hi;
        int          t;
        pick = $urandom_range(0, 9);
        lo = int'((cct_warm_k < cct_cool_k) ? cct_warm_k : cct_cool_k);
        hi = int'((cct_warm_k < cct_cool_k) ? cct_cool_k : cct_warm_k);
        if (pick < 3)
            return 16'($urandom);
        if (pick == 8)
            return 16'(cct_warm_k);
        if (pick == 9)
            return 16'(cct_cool_k);
        t = lo - 300 + int'($urandom_range(0, hi - lo + 600));
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return 16'(t);
    endfunction

    function automatic logic [lcbm_pkg::BRIGHT_W-1:0] rand_bright();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 7'($urandom_range(101, 127));
        if (pick == 1)
            return 7'($urandom_range(0, 12));
        return 7'($urandom_range(0, 100));
    endfunction

    // random requests under a series of limit settings, one without idling
    task automatic test_random_settings();
        int unsigned lo_pwm;
        int unsigned hi_pwm;
        int unsigned lo_k;
        int unsigned hi_k;
        for (int s = 0; s < 8; s++) begin
            case (s)
                0: begin lo_pwm = 0;   hi_pwm = 255; lo_k = 2700;  hi_k = 6500;  end
                1: begin lo_pwm = 0;   hi_pwm = 255; lo_k = 0;     hi_k = 65535; end
                2: begin lo_pwm = 255; hi_pwm = 255; lo_k = 65535; hi_k = 65535; end
                3: begin lo_pwm = 0;   hi_pwm = 0;   lo_k = 0;     hi_k = 0;     end
                4: begin lo_pwm = 30;  hi_pwm = 220; lo_k = 1800;  hi_k = 9000;  end
                default: begin
                    lo_pwm = $urandom_range(0, 255);
                    hi_pwm = $urandom_range(0, 255);
                    // keep most pwm settings well ordered
                    if (hi_pwm < lo_pwm && $urandom_range(0, 3) != 0) begin
                        hi_pwm = lo_pwm;
                        lo_pwm = $urandom_range(0, hi_pwm);
                    end
                    lo_k = $urandom_range(1000, 5000);
                    hi_k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                      : lo_k + $urandom_range(1, 8000);
                end
            endcase
            program_limits(lo_pwm, hi_pwm, lo_k, hi_k);
            idle_on = (s != 4);
            for (int i = 0; i < SETTING_ITEMS; i++)
                send_request(1'($urandom), rand_color(), rand_color(), rand_color(),
                             rand_temp(), rand_bright());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rgb_curve();
        test_cct_clamp();
        test_inverted_limits();
        test_random_settings();
        quiesce();
        if (mismatch_count == 0 && pending_duty.size() == 0)
            $display("** lamp_color_brightness_mapper: PASSED **");
        else
            $display("** lamp_color_brightness_mapper: FAILED **");
        $finish;
    end

endmodule

### lamp_color_brightness_mapper.f
hdl/lcbm_pkg.sv
hdl/lcbm_div.sv
hdl/lamp_color_brightness_mapper.sv
bench/lamp_color_brightness_mapper_tb.sv
